### src/md2_pkg.sv
// md2 engine package: constants, substitution table, controller/datapath interface types
`timescale 1ns / 1ps

package md2_pkg;

  localparam int BLK_BYTES  = 16;
  localparam int WORK_BYTES = 48;
  localparam int ROUNDS     = 18;

  localparam int STEP_W  = $clog2(WORK_BYTES);
  localparam int ROUND_W = $clog2(ROUNDS);
  localparam int IDX_W   = $clog2(BLK_BYTES);

  // input item kinds carried on tuser
  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // md2 substitution table (digits of pi)
  localparam logic [7:0] SBOX [256] = '{
    8'd41,  8'd46,  8'd67,  8'd201, 8'd162, 8'd216, 8'd124, 8'd1,
    8'd61,  8'd54,  8'd84,  8'd161, 8'd236, 8'd240, 8'd6,   8'd19,
    8'd98,  8'd167, 8'd5,   8'd243, 8'd192, 8'd199, 8'd115, 8'd140,
    8'd152, 8'd147, 8'd43,  8'd217, 8'd188, 8'd76,  8'd130, 8'd202,
    8'd30,  8'd155, 8'd87,  8'd60,  8'd253, 8'd212, 8'd224, 8'd22,
    8'd103, 8'd66,  8'd111, 8'd24,  8'd138, 8'd23,  8'd229, 8'd18,
    8'd190, 8'd78,  8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47,  8'd238, 8'd122,
    8'd169, 8'd104, 8'd121, 8'd145, 8'd21,  8'd178, 8'd7,   8'd63,
    8'd148, 8'd194, 8'd16,  8'd137, 8'd11,  8'd34,  8'd95,  8'd33,
    8'd128, 8'd127, 8'd93,  8'd154, 8'd90,  8'd144, 8'd50,  8'd39,
    8'd53,  8'd62,  8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3,
    8'd255, 8'd25,  8'd48,  8'd179, 8'd72,  8'd165, 8'd181, 8'd209,
    8'd215, 8'd94,  8'd146, 8'd42,  8'd172, 8'd86,  8'd170, 8'd198,
    8'd79,  8'd184, 8'd56,  8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4,   8'd241,
    8'd69,  8'd157, 8'd112, 8'd89,  8'd100, 8'd113, 8'd135, 8'd32,
    8'd134, 8'd91,  8'd207, 8'd101, 8'd230, 8'd45,  8'd168, 8'd2,
    8'd27,  8'd96,  8'd37,  8'd173, 8'd174, 8'd176, 8'd185, 8'd246,
    8'd28,  8'd70,  8'd97,  8'd105, 8'd52,  8'd64,  8'd126, 8'd15,
    8'd85,  8'd71,  8'd163, 8'd35,  8'd221, 8'd81,  8'd175, 8'd58,
    8'd195, 8'd92,  8'd249, 8'd206, 8'd186, 8'd197, 8'd234, 8'd38,
    8'd44,  8'd83,  8'd13,  8'd110, 8'd133, 8'd40,  8'd132, 8'd9,
    8'd211, 8'd223, 8'd205, 8'd244, 8'd65,  8'd129, 8'd77,  8'd82,
    8'd106, 8'd220, 8'd55,  8'd200, 8'd108, 8'd193, 8'd171, 8'd250,
    8'd36,  8'd225, 8'd123, 8'd8,   8'd12,  8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99,  8'd232, 8'd109,
    8'd233, 8'd203, 8'd213, 8'd254, 8'd59,  8'd0,   8'd29,  8'd57,
    8'd242, 8'd239, 8'd183, 8'd14,  8'd102, 8'd88,  8'd208, 8'd228,
    8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75,  8'd10,
    8'd49,  8'd68,  8'd80,  8'd180, 8'd143, 8'd237, 8'd31,  8'd26,
    8'd219, 8'd153, 8'd141, 8'd51,  8'd159, 8'd17,  8'd131, 8'd20
  };

  // commands from controller to datapath
  typedef struct packed {
    logic               absorb;     // store input byte in block buffer
    logic               load;       // fill work buffer from chain and a block
    logic               src_chk;    // block source is the checksum
    logic               pad;        // pad block entries past the fill count
    logic               step;       // one table lookup of the round loop
    logic               round_end;  // last lookup of a round
    logic [ROUND_W-1:0] round;      // current round number
    logic               chk_en;     // update checksum in this step
    logic               emit;       // move one digest byte to the output register
    logic [IDX_W-1:0]   emit_idx;   // position of that byte
    logic               clear;      // return all state to reset values
  } md2_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic fill_last;  // block buffer holds 15 bytes
  } md2_stat_t;

endpackage

### src/md2_dp.sv
// md2 datapath: block buffer, rotating work buffer, checksum, output register
`timescale 1ns / 1ps

module md2_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  md2_pkg::md2_cmd_t             cmd,
  input  logic [7:0]                    in_byte,
  output md2_pkg::md2_stat_t            stat,
  output logic [7:0]                    out_byte,
  output logic [md2_pkg::IDX_W-1:0]     out_idx,
  output logic                          out_last
);

  logic [7:0] x_r   [md2_pkg::WORK_BYTES];
  logic [7:0] chk_r [md2_pkg::BLK_BYTES];
  logic [7:0] blk_r [md2_pkg::BLK_BYTES];
  logic [7:0] m_w   [md2_pkg::BLK_BYTES];
  logic [md2_pkg::IDX_W-1:0] fill_r;
  logic [7:0] t_r, t_nxt, tc_r, x_new, c_new, pad_byte;
  logic [md2_pkg::IDX_W:0] pad_w;
  logic [7:0] out_byte_r;
  logic [md2_pkg::IDX_W-1:0] out_idx_r;
  logic out_last_r;

  assign stat.fill_last = (fill_r == md2_pkg::IDX_W'(md2_pkg::BLK_BYTES - 1));

  // block for compression: stored bytes, padding, or checksum
  assign pad_w    = (md2_pkg::IDX_W + 1)'(md2_pkg::BLK_BYTES) - {1'b0, fill_r};
  assign pad_byte = 8'(pad_w);
  always_comb begin
    for (int k = 0; k < md2_pkg::BLK_BYTES; k++) begin
      if (cmd.src_chk) begin
        m_w[k] = chk_r[k];
      end else if (cmd.pad && (md2_pkg::IDX_W'(k) >= fill_r)) begin
        m_w[k] = pad_byte;
      end else begin
        m_w[k] = blk_r[k];
      end
    end
  end

  // one lookup: head of work buffer mixed with table entry of the running byte
  assign x_new = x_r[0] ^ md2_pkg::SBOX[t_r];
  assign t_nxt = cmd.round_end ? (x_new + 8'(cmd.round)) : x_new;
  // checksum lookup: block byte k sits at work position 16 in step k of round 0
  assign c_new = chk_r[0] ^ md2_pkg::SBOX[x_r[md2_pkg::BLK_BYTES] ^ tc_r];

  // block buffer, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      blk_r[fill_r] <= in_byte;
    end
  end

  // work buffer, checksum and running bytes
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int k = 0; k < md2_pkg::WORK_BYTES; k++) x_r[k] <= 8'd0;
      for (int k = 0; k < md2_pkg::BLK_BYTES; k++) chk_r[k] <= 8'd0;
      fill_r <= '0;
      t_r    <= 8'd0;
      tc_r   <= 8'd0;
    end else begin
      if (cmd.absorb) begin
        fill_r <= fill_r + 1'b1;
      end
      if (cmd.load) begin
        for (int k = 0; k < md2_pkg::BLK_BYTES; k++) begin
          x_r[k + md2_pkg::BLK_BYTES]     <= m_w[k];
          x_r[k + 2 * md2_pkg::BLK_BYTES] <= x_r[k] ^ m_w[k];
        end
        t_r  <= 8'd0;
        tc_r <= chk_r[md2_pkg::BLK_BYTES - 1];
      end else if (cmd.step) begin
        for (int k = 0; k < md2_pkg::WORK_BYTES - 1; k++) x_r[k] <= x_r[k + 1];
        x_r[md2_pkg::WORK_BYTES - 1] <= x_new;
        t_r <= t_nxt;
        if (cmd.chk_en) begin
          for (int k = 0; k < md2_pkg::BLK_BYTES - 1; k++) chk_r[k] <= chk_r[k + 1];
          chk_r[md2_pkg::BLK_BYTES - 1] <= c_new;
          tc_r <= c_new;
        end
      end else if (cmd.emit) begin
        // rotate chain so the next digest byte is at the head
        for (int k = 0; k < md2_pkg::BLK_BYTES - 1; k++) x_r[k] <= x_r[k + 1];
        x_r[md2_pkg::BLK_BYTES - 1] <= x_r[0];
      end
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte_r <= x_r[0];
      out_idx_r  <= cmd.emit_idx;
      out_last_r <= (cmd.emit_idx == md2_pkg::IDX_W'(md2_pkg::BLK_BYTES - 1));
    end
  end

  assign out_byte = out_byte_r;
  assign out_idx  = out_idx_r;
  assign out_last = out_last_r;

endmodule

### src/md2_ctrl.sv
// md2 controller: sequencing of absorb, compression rounds and digest output
`timescale 1ns / 1ps

module md2_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  output logic                out_valid,
  input  logic                out_ready,
  input  md2_pkg::md2_stat_t  stat,
  output md2_pkg::md2_cmd_t   cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_COMP = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [md2_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [md2_pkg::ROUND_W-1:0] round_r, round_nxt;
  logic [md2_pkg::IDX_W-1:0]   emit_r, emit_nxt;
  logic fin_r, fin_nxt, src_chk_r, src_chk_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept, last_step, last_round, slot_free;

  assign in_ready   = (state_r == ST_IDLE);
  assign accept     = in_valid && in_ready;
  assign last_step  = (step_r == md2_pkg::STEP_W'(md2_pkg::WORK_BYTES - 1));
  assign last_round = (round_r == md2_pkg::ROUND_W'(md2_pkg::ROUNDS - 1));
  assign slot_free  = !out_valid_r || out_ready;
  assign out_valid  = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    round_nxt     = round_r;
    emit_nxt      = emit_r;
    fin_nxt       = fin_r;
    src_chk_nxt   = src_chk_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.round     = round_r;
    cmd.emit_idx  = emit_r;
    cmd.src_chk   = src_chk_r;
    cmd.pad       = fin_r && !src_chk_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == md2_pkg::MODE_FINISH) begin
            fin_nxt   = 1'b1;
            state_nxt = ST_LOAD;
          end else begin
            cmd.absorb = 1'b1;
            if (stat.fill_last) state_nxt = ST_LOAD;
          end
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        step_nxt  = '0;
        round_nxt = '0;
        state_nxt = ST_COMP;
      end
      ST_COMP: begin
        cmd.step      = 1'b1;
        cmd.round_end = last_step;
        cmd.chk_en    = (round_r == '0) && (step_r < md2_pkg::STEP_W'(md2_pkg::BLK_BYTES));
        step_nxt      = last_step ? '0 : step_r + 1'b1;
        if (last_step) begin
          round_nxt = round_r + 1'b1;
          if (last_round) begin
            if (!fin_r) begin
              state_nxt = ST_IDLE;
            end else if (!src_chk_r) begin
              src_chk_nxt = 1'b1;
              state_nxt   = ST_LOAD;
            end else begin
              emit_nxt  = '0;
              state_nxt = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          emit_nxt      = emit_r + 1'b1;
          if (emit_r == md2_pkg::IDX_W'(md2_pkg::BLK_BYTES - 1)) begin
            cmd.clear   = 1'b1;
            fin_nxt     = 1'b0;
            src_chk_nxt = 1'b0;
            state_nxt   = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      round_r     <= '0;
      emit_r      <= '0;
      fin_r       <= 1'b0;
      src_chk_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      round_r     <= round_nxt;
      emit_r      <= emit_nxt;
      fin_r       <= fin_nxt;
      src_chk_r   <= src_chk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### src/md2_hash_engine.sv
// md2 hash engine top level: controller and datapath
//
//   channel | direction | tdata                        | tuser / tlast
//   in_     | slave     | [7:0] data_byte              | tuser: mode
//   out_    | master    | [7:0] digest_byte, [11:8] byte_index | tlast: last_flag
//
// an absorb item is stored in the block buffer; the one that completes a block adds a load step and
// the compression (18 rounds of 48 lookups, one lookup per cycle)
// a finish item starts a load and compression of the padded block, then of the checksum
// block, then 16 digest items, one per cycle while out_tready is high
// reset clears chain, checksum and fill count at once; no clearing pass
// the output register lets the last digest item wait while the next message is taken
`timescale 1ns / 1ps

module md2_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] digest_byte, [11:8] byte_index, zero above
  output logic        out_tlast
);

  md2_pkg::md2_cmd_t  cmd;
  md2_pkg::md2_stat_t stat;
  logic [7:0] out_byte;
  logic [md2_pkg::IDX_W-1:0] out_idx;

  // sequencing
  md2_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // data storage and lookups
  md2_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_byte  (in_tdata),
    .stat     (stat),
    .out_byte (out_byte),
    .out_idx  (out_idx),
    .out_last (out_tlast)
  );

  assign out_tdata = {4'd0, out_idx, out_byte};

endmodule

### src/md2_chk.sv
// md2 port checker and its bind to the top level
`timescale 1ns / 1ps

module md2_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast
);

  // a stalled item stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out item dropped while stalled");

  // a stalled item keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("out payload changed while stalled");

  // tlast marks exactly the final digest position
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[11:8] == 4'hf)))
    else $error("tlast does not match byte index");

  // a finish item starts compression, so no item is taken right after
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("input taken right after finish item");

  // digest bytes carry a zero pad above the index
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15:12] == 4'd0))
    else $error("nonzero pad in out tdata");

endmodule

bind md2_hash_engine md2_chk u_md2_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
